FILE: src/ups_pkg.sv
// Shared types and constants for the UDP port packet steering block.
package ups_pkg;

    // Sizing
    localparam int TABLE_ENTRIES   = 64;
    localparam int QUEUE_COUNT     = 256;
    localparam int MAX_FRAME_BYTES = 16383;

    localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W   = POS_W + 1;
    localparam int TIDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int GROUP   = 8;
    localparam int NGROUPS = (TABLE_ENTRIES + GROUP - 1) / GROUP;

    // Field widths fixed by the stream format
    localparam int BYTE_W  = 8;
    localparam int QUEUE_W = 8;
    localparam int INDEX_W = 6;
    localparam int PORT_W  = 16;
    localparam int TP_W    = 24;
    localparam int IHL_W   = 4;
    localparam int OFS_W   = 7;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Frame layout and checks
    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES  = LEN_W'(60);
    localparam logic [TP_W-1:0]  IPV4_UDP_TAG     = 24'h080011;
    localparam logic [3:0]       IHL_MASK         = 4'hf;
    localparam logic [OFS_W-1:0] UDP_TAIL_BYTES   = 7'd16;
    localparam logic [OFS_W-1:0] ETH_HEADER_BYTES = 7'd14;
    localparam logic [OFS_W-1:0] PORT_HI_OFS      = ETH_HEADER_BYTES + 7'd2;
    localparam logic [OFS_W-1:0] UDP_END_OFS      = ETH_HEADER_BYTES + UDP_TAIL_BYTES;
    localparam logic [POS_W-1:0] POS_TYPE_HI      = POS_W'(12);
    localparam logic [POS_W-1:0] POS_TYPE_LO      = POS_W'(13);
    localparam logic [POS_W-1:0] POS_IHL          = POS_W'(14);
    localparam logic [POS_W-1:0] POS_PROTO        = POS_W'(23);

    // Job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TABLE = 1'b1
    } cmd_t;

    // One job: a table write, or a frame lookup with its pre-checked flag
    typedef struct packed {
        cmd_t                 kind;
        logic [PORT_W-1:0]    port;
        logic [INDEX_W-1:0]   index;
        logic                 flag;   // entry valid bit, or frame checks passed
        logic [QUEUE_W-1:0]   queue;
    } job_t;

endpackage

FILE: src/ups_front.sv
// Front end: parses frame bytes, captures header fields and emits jobs.
module ups_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          beat_ok,   // input beat accepted
    input  ups_pkg::cmd_t                 command,
    input  logic [ups_pkg::BYTE_W-1:0]    frame_byte,
    input  logic                          end_of_frame,
    input  logic [ups_pkg::QUEUE_W-1:0]   receive_queue,
    input  logic [ups_pkg::INDEX_W-1:0]   entry_index,
    input  logic [ups_pkg::PORT_W-1:0]    entry_port,
    input  logic                          entry_valid,
    output logic                          push,
    output ups_pkg::job_t                 job
);

    logic [ups_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [ups_pkg::TP_W-1:0]   tp_reg,   tp_next;
    logic [ups_pkg::IHL_W-1:0]  hw_reg,   hw_next;
    logic [ups_pkg::PORT_W-1:0] port_reg, port_next;

    logic [ups_pkg::OFS_W-1:0]  port_hi;
    logic [ups_pkg::OFS_W-1:0]  udp_end;
    logic [ups_pkg::LEN_W-1:0]  frame_len;
    logic                       checks_ok;

    // Capture offsets and frame length
    assign port_hi   = {1'b0, hw_reg, 2'b00} + ups_pkg::PORT_HI_OFS;
    assign udp_end   = {1'b0, hw_next, 2'b00} + ups_pkg::UDP_END_OFS;
    assign frame_len = ups_pkg::LEN_W'(pos_reg) + ups_pkg::LEN_W'(1);

    // Header checks at the last byte, using this beat's captures
    assign checks_ok = (frame_len >= ups_pkg::MIN_FRAME_BYTES)
                    && (tp_next == ups_pkg::IPV4_UDP_TAG)
                    && (ups_pkg::LEN_W'(udp_end) < frame_len)
                    && (32'(receive_queue) < ups_pkg::QUEUE_COUNT);

    // Advance parse state on frame beats
    always_comb
    begin
        pos_next  = pos_reg;
        tp_next   = tp_reg;
        hw_next   = hw_reg;
        port_next = port_reg;
        if (beat_ok && command == ups_pkg::CMD_FRAME)
        begin
            if (pos_reg == ups_pkg::POS_TYPE_HI)
                tp_next = {frame_byte, tp_reg[15:0]};
            else if (pos_reg == ups_pkg::POS_TYPE_LO)
                tp_next = {tp_reg[23:16], frame_byte, tp_reg[7:0]};
            else if (pos_reg == ups_pkg::POS_PROTO)
                tp_next = {tp_reg[23:8], frame_byte};

            if (pos_reg == ups_pkg::POS_IHL)
                hw_next = frame_byte[3:0] & ups_pkg::IHL_MASK;

            if (pos_reg == ups_pkg::POS_W'(port_hi))
                port_next = {frame_byte, port_reg[7:0]};
            else if (pos_reg == ups_pkg::POS_W'(port_hi) + ups_pkg::POS_W'(1))
                port_next = {port_reg[15:8], frame_byte};

            if (32'(pos_reg) < ups_pkg::MAX_FRAME_BYTES)
                pos_next = pos_reg + ups_pkg::POS_W'(1);
        end
    end

    // Build the job for table writes and frame ends
    always_comb
    begin
        push      = 1'b0;
        job.kind  = command;
        job.port  = entry_port;
        job.index = entry_index;
        job.flag  = entry_valid;
        job.queue = receive_queue;
        unique case (command)
            ups_pkg::CMD_TABLE:
            begin
                push = beat_ok;
            end
            ups_pkg::CMD_FRAME:
            begin
                push     = beat_ok && end_of_frame;
                job.port = port_next;
                job.flag = checks_ok;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Hold parse state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            tp_reg   <= '0;
            hw_reg   <= '0;
            port_reg <= '0;
        end
        else if (beat_ok && command == ups_pkg::CMD_FRAME && end_of_frame)
        begin
            pos_reg  <= '0;
            tp_reg   <= '0;
            hw_reg   <= '0;
            port_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            tp_reg   <= tp_next;
            hw_reg   <= hw_next;
            port_reg <= port_next;
        end
    end

endmodule

FILE: src/ups_fifo.sv
// Short job queue between the front end and the back end.
module ups_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ups_pkg::job_t   push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ups_pkg::job_t   head_job
);

    ups_pkg::job_t                 mem_reg [ups_pkg::FIFO_DEPTH];
    logic [ups_pkg::FPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ups_pkg::FPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ups_pkg::FCNT_W-1:0]    count_reg,  count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (32'(count_reg) == ups_pkg::FIFO_DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + ups_pkg::FPTR_W'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + ups_pkg::FPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + ups_pkg::FCNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - ups_pkg::FCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: src/ups_back.sv
// Back end: port table, parallel port match and verdict output register.
module ups_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  ups_pkg::job_t                 head_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          verdict,
    output logic [ups_pkg::QUEUE_W-1:0]   target_queue
);

    logic                        tbl_valid_reg [ups_pkg::TABLE_ENTRIES];
    logic [ups_pkg::PORT_W-1:0]  tbl_port_reg  [ups_pkg::TABLE_ENTRIES];

    logic                         s1_valid_reg;
    logic [ups_pkg::NGROUPS-1:0]  s1_hit_reg;
    logic                         s1_ok_reg;
    logic [ups_pkg::QUEUE_W-1:0]  s1_queue_reg;

    logic                         out_valid_reg;
    logic                         out_verdict_reg;
    logic [ups_pkg::QUEUE_W-1:0]  out_queue_reg;

    logic [ups_pkg::NGROUPS-1:0]  group_hit;
    logic                         out_free;
    logic                         s1_free;
    logic                         is_write;
    logic                         tbl_we;
    logic                         s1_load;
    logic                         redirect;

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign is_write  = (head_job.kind == ups_pkg::CMD_TABLE);
    assign pop       = head_valid && (is_write || s1_free);
    assign tbl_we    = pop && is_write
                    && (32'(head_job.index) < ups_pkg::TABLE_ENTRIES);
    assign s1_load   = pop && !is_write;
    assign redirect  = s1_ok_reg && (s1_hit_reg != '0);

    assign out_valid    = out_valid_reg;
    assign verdict      = out_verdict_reg;
    assign target_queue = out_queue_reg;

    // Compare the port against every entry, reduced per group of eight
    always_comb
    begin
        for (int g = 0; g < ups_pkg::NGROUPS; g++)
        begin
            group_hit[g] = 1'b0;
            for (int k = 0; k < ups_pkg::GROUP; k++)
            begin
                if (g * ups_pkg::GROUP + k < ups_pkg::TABLE_ENTRIES)
                begin
                    if (tbl_valid_reg[g * ups_pkg::GROUP + k]
                        && tbl_port_reg[g * ups_pkg::GROUP + k] == head_job.port)
                        group_hit[g] = 1'b1;
                end
            end
        end
    end

    // Table valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ups_pkg::TABLE_ENTRIES; i++)
                tbl_valid_reg[i] <= 1'b0;
        end
        else if (tbl_we)
        begin
            tbl_valid_reg[ups_pkg::TIDX_W'(head_job.index)] <= head_job.flag;
        end
    end

    // Table ports
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_port_reg[ups_pkg::TIDX_W'(head_job.index)] <= head_job.port;
    end

    // Match stage and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s1_load;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Match stage and output register payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_hit_reg   <= group_hit;
            s1_ok_reg    <= head_job.flag;
            s1_queue_reg <= head_job.queue;
        end
        if (out_free && s1_valid_reg)
        begin
            out_verdict_reg <= redirect;
            out_queue_reg   <= redirect ? s1_queue_reg : '0;
        end
    end

endmodule

FILE: src/udp_port_packet_steering_top.sv
// Top level of the UDP port packet steering block.
//
// Takes one beat per clock while the input is not stalled: a frame byte
// (tuser 0) or a port table write (tuser 1). Frame bytes are parsed on the
// fly; at the byte marked with tlast one verdict beat comes out, redirect
// (tuser 1) with the receive queue in tdata, or pass (tuser 0) with tdata
// zero. Table writes give no output beat and take effect for every frame
// whose last byte arrives after them. A frame verdict passes through the
// four-entry job queue, the match stage and the output register; the queue
// absorbs output stalls, and the input stalls only when it is full.
// The port match compares all table entries at once in one pipeline stage.
module udp_port_packet_steering_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] frame_byte, [15:8] receive_queue, [21:16] entry_index,
    // [37:22] entry_port, [38] entry_valid, [39] zero
    input  logic [ups_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] target_queue
    output logic [ups_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] verdict
    output logic                              m_axis_tuser
);

    logic           beat_ok;
    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;
    ups_pkg::job_t  push_job;
    ups_pkg::job_t  head_job;
    ups_pkg::cmd_t  command;

    assign s_axis_tready = !full;
    assign beat_ok       = s_axis_tvalid && !full;
    assign command       = ups_pkg::cmd_t'(s_axis_tuser);

    // Parse and classify input beats
    ups_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat_ok       (beat_ok),
        .command       (command),
        .frame_byte    (s_axis_tdata[7:0]),
        .end_of_frame  (s_axis_tlast),
        .receive_queue (s_axis_tdata[15:8]),
        .entry_index   (s_axis_tdata[21:16]),
        .entry_port    (s_axis_tdata[37:22]),
        .entry_valid   (s_axis_tdata[38]),
        .push          (push),
        .job           (push_job)
    );

    // Queue jobs between the two halves
    ups_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Apply table writes and produce verdicts
    ups_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .verdict      (m_axis_tuser),
        .target_queue (m_axis_tdata)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the UDP port packet steering block.
module tb_top;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 700;
    localparam int LONG_BYTES   = 256;
    localparam int IDLE_PCT     = 9;

    typedef enum int {
        HDR_GOOD,
        HDR_BAD_TYPE,
        HDR_BAD_PROTO
    } hdr_flaw_t;

    typedef struct {
        logic                        verdict;
        logic [ups_pkg::QUEUE_W-1:0] queue;
    } verdict_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ups_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ups_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tuser;

    // Shadow of the block's parser and port table
    logic [ups_pkg::POS_W-1:0]   frame_pos = '0;
    logic [ups_pkg::TP_W-1:0]    type_proto = '0;
    logic [ups_pkg::IHL_W-1:0]   ihl = '0;
    logic [ups_pkg::PORT_W-1:0]  dst_port = '0;
    logic                        slot_valid [ups_pkg::TABLE_ENTRIES];
    logic [ups_pkg::PORT_W-1:0]  slot_port [ups_pkg::TABLE_ENTRIES];

    verdict_t                    pending_verdicts [$];
    logic [ups_pkg::PORT_W-1:0]  hot_ports [8];

    bit steady = 1'b0;
    int holds_requested = 0;
    int holds_served = 0;
    int errors = 0;
    int cycle_count = 0;
    int beats_sent = 0;
    int frames_sent = 0;
    int entry_writes = 0;
    int verdicts_expected = 0;
    int redirects_seen = 0;
    int passes_seen = 0;

    udp_port_packet_steering_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, pending_verdicts.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Parse one accepted beat; return 1 with the verdict when it ends a frame
    function automatic bit steer_beat(input ups_pkg::cmd_t cmd,
                                      input logic [ups_pkg::BYTE_W-1:0] fbyte,
                                      input logic last,
                                      input logic [ups_pkg::QUEUE_W-1:0] q,
                                      input logic [ups_pkg::INDEX_W-1:0] idx,
                                      input logic [ups_pkg::PORT_W-1:0] prt,
                                      input logic v,
                                      output verdict_t res);
        int  pos;
        int  port_at;
        int  flen;
        bit  hit;
        res.verdict = 1'b0;
        res.queue   = '0;
        if (cmd == ups_pkg::CMD_TABLE)
        begin
            if (int'(idx) < ups_pkg::TABLE_ENTRIES)
            begin
                slot_valid[idx] = v;
                slot_port[idx]  = prt;
            end
            entry_writes++;
            return 1'b0;
        end
        pos     = int'(frame_pos);
        port_at = 4 * int'(ihl) + int'(ups_pkg::PORT_HI_OFS);
        if (pos == int'(ups_pkg::POS_TYPE_HI))
            type_proto[23:16] = fbyte;
        else if (pos == int'(ups_pkg::POS_TYPE_LO))
            type_proto[15:8] = fbyte;
        else if (pos == int'(ups_pkg::POS_PROTO))
            type_proto[7:0] = fbyte;
        if (pos == int'(ups_pkg::POS_IHL))
            ihl = fbyte[ups_pkg::IHL_W-1:0];
        if (pos == port_at)
            dst_port[15:8] = fbyte;
        else if (pos == port_at + 1)
            dst_port[7:0] = fbyte;
        // Saturate the position on oversized frames
        if (pos < ups_pkg::MAX_FRAME_BYTES)
            frame_pos = frame_pos + ups_pkg::POS_W'(1);
        if (!last)
            return 1'b0;
        hit = 1'b0;
        for (int k = 0; k < ups_pkg::TABLE_ENTRIES; k++)
            if (slot_valid[k] && slot_port[k] == dst_port)
                hit = 1'b1;
        flen = pos + 1;
        res.verdict = (flen >= int'(ups_pkg::MIN_FRAME_BYTES))
                      && (type_proto == ups_pkg::IPV4_UDP_TAG)
                      && (4 * int'(ihl) + int'(ups_pkg::UDP_END_OFS) < flen) && hit
                      && (int'(q) < ups_pkg::QUEUE_COUNT);
        res.queue = res.verdict ? q : '0;
        frame_pos  = '0;
        type_proto = '0;
        ihl        = '0;
        dst_port   = '0;
        frames_sent++;
        return 1'b1;
    endfunction

    // Offer one beat with random gaps, hold until accepted, then predict
    task automatic send_beat(input ups_pkg::cmd_t cmd, input logic [ups_pkg::BYTE_W-1:0] fbyte,
                             input logic last, input logic [ups_pkg::QUEUE_W-1:0] q,
                             input logic [ups_pkg::INDEX_W-1:0] idx,
                             input logic [ups_pkg::PORT_W-1:0] prt,
                             input logic v);
        verdict_t res;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, v, prt, idx, q, fbyte};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        if (steer_beat(cmd, fbyte, last, q, idx, prt, v, res))
        begin
            pending_verdicts.push_back(res);
            verdicts_expected++;
        end
    endtask

    task automatic send_byte(input logic [ups_pkg::BYTE_W-1:0] fbyte, input logic last,
                             input logic [ups_pkg::QUEUE_W-1:0] q);
        send_beat(ups_pkg::CMD_FRAME, fbyte, last, q, ups_pkg::INDEX_W'($urandom),
                  ups_pkg::PORT_W'($urandom), 1'($urandom));
    endtask

    // Table write; the frame fields carry random junk
    task automatic write_entry(input logic [ups_pkg::INDEX_W-1:0] idx,
                               input logic [ups_pkg::PORT_W-1:0] prt,
                               input logic v);
        send_beat(ups_pkg::CMD_TABLE, ups_pkg::BYTE_W'($urandom), 1'($urandom),
                  ups_pkg::QUEUE_W'($urandom), idx, prt, v);
    endtask

    task automatic write_random_entry();
        logic [ups_pkg::PORT_W-1:0] prt;
        prt = ($urandom_range(99) < 70) ? hot_ports[$urandom_range(7)]
                                        : ups_pkg::PORT_W'($urandom);
        write_entry(ups_pkg::INDEX_W'($urandom), prt, $urandom_range(99) < 80);
    endtask

    // Build and send one frame; arm_at >= 0 enables its port just before that byte
    task automatic send_frame(input int len, input logic [ups_pkg::IHL_W-1:0] ihl_n,
                              input logic [ups_pkg::PORT_W-1:0] dport,
                              input logic [ups_pkg::QUEUE_W-1:0] q,
                              input hdr_flaw_t flaw, input int arm_at, input int sprinkle_pct);
        int                         port_at;
        logic [ups_pkg::BYTE_W-1:0] b;
        port_at = 4 * int'(ihl_n) + int'(ups_pkg::PORT_HI_OFS);
        for (int i = 0; i < len; i++)
        begin
            if (i == arm_at)
                write_entry(ups_pkg::INDEX_W'($urandom), dport, 1'b1);
            if (sprinkle_pct > 0 && $urandom_range(99) < sprinkle_pct)
                write_random_entry();
            b = ups_pkg::BYTE_W'($urandom);
            if (i == int'(ups_pkg::POS_TYPE_HI))
                b = ups_pkg::IPV4_UDP_TAG[23:16];
            else if (i == int'(ups_pkg::POS_TYPE_LO))
                b = (flaw == HDR_BAD_TYPE)
                    ? ups_pkg::IPV4_UDP_TAG[15:8] ^ ups_pkg::BYTE_W'($urandom_range(255, 1))
                    : ups_pkg::IPV4_UDP_TAG[15:8];
            else if (i == int'(ups_pkg::POS_IHL))
                b[ups_pkg::IHL_W-1:0] = ihl_n;
            else if (i == int'(ups_pkg::POS_PROTO))
                b = (flaw == HDR_BAD_PROTO)
                    ? ups_pkg::IPV4_UDP_TAG[7:0] ^ ups_pkg::BYTE_W'($urandom_range(255, 1))
                    : ups_pkg::IPV4_UDP_TAG[7:0];
            else if (i == port_at)
                b = dport[15:8];
            else if (i == port_at + 1)
                b = dport[7:0];
            send_byte(b, i == len - 1, (i == len - 1) ? q : ups_pkg::QUEUE_W'($urandom));
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served < holds_requested)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each verdict beat with the oldest expectation
    always @(posedge clk)
    begin : verdict_check
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict beat with none expected: verdict %0d target_queue %0d",
                       m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tuser !== want.verdict)
                begin
                    $error("verdict mismatch: expected %0d, actual %0d",
                           want.verdict, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.queue)
                begin
                    $error("target_queue mismatch: expected %0d, actual %0d",
                           want.queue, m_axis_tdata);
                    errors++;
                end
                if (want.verdict)
                    redirects_seen++;
                else
                    passes_seen++;
            end
        end
    end

    // Empty table: even port zero must not match
    task automatic test_empty_table();
        send_frame(64, 4'd5, 16'h0000, 8'h12, HDR_GOOD, -1, 0);
    endtask

    // Extreme slots, ports and queues; removal of an entry
    task automatic test_table_extremes();
        write_entry(6'd0, 16'hffff, 1'b1);
        write_entry(6'd63, 16'h0000, 1'b1);
        send_frame(60, 4'd5, 16'hffff, 8'hff, HDR_GOOD, -1, 0);
        send_frame(60, 4'd5, 16'h0000, 8'h00, HDR_GOOD, -1, 0);
        write_entry(6'd63, 16'h0000, 1'b0);
        send_frame(60, 4'd5, 16'h0000, 8'h3c, HDR_GOOD, -1, 0);
    endtask

    // Minimum length and header length boundaries
    task automatic test_length_rules();
        write_entry(6'd5, 16'h1234, 1'b1);
        send_frame(59, 4'd5, 16'h1234, 8'h01, HDR_GOOD, -1, 0);
        send_frame(60, 4'd5, 16'h1234, 8'h02, HDR_GOOD, -1, 0);
        send_frame(90, 4'd15, 16'h1234, 8'h03, HDR_GOOD, -1, 0);
        send_frame(91, 4'd15, 16'h1234, 8'h04, HDR_GOOD, -1, 0);
        send_frame(60, 4'd0, 16'h1234, 8'h05, HDR_GOOD, -1, 0);
        send_frame(1, 4'd5, 16'h1234, 8'h06, HDR_GOOD, -1, 0);
    endtask

    // Wrong EtherType, wrong IP protocol
    task automatic test_header_rules();
        send_frame(64, 4'd5, 16'h1234, 8'h07, HDR_BAD_TYPE, -1, 0);
        send_frame(64, 4'd5, 16'h1234, 8'h08, HDR_BAD_PROTO, -1, 0);
    endtask

    // Two slots with one port act as one until both are removed
    task automatic test_duplicate_ports();
        write_entry(6'd10, 16'hbeef, 1'b1);
        write_entry(6'd11, 16'hbeef, 1'b1);
        send_frame(62, 4'd5, 16'hbeef, 8'h21, HDR_GOOD, -1, 0);
        write_entry(6'd10, 16'hbeef, 1'b0);
        send_frame(62, 4'd5, 16'hbeef, 8'h22, HDR_GOOD, -1, 0);
        write_entry(6'd11, 16'hbeef, 1'b0);
        send_frame(62, 4'd5, 16'hbeef, 8'h23, HDR_GOOD, -1, 0);
    endtask

    // Table write in the middle of a frame counts for that frame
    task automatic test_mid_frame_write();
        send_frame(70, 4'd6, 16'hcafe, 8'h44, HDR_GOOD, 40, 0);
    endtask

    // Long frame streamed with no idling on either side
    task automatic test_long_frame();
        write_entry(6'd1, 16'h0101, 1'b1);
        steady = 1'b1;
        send_frame(LONG_BYTES, 4'd5, 16'h0101, 8'h5a, HDR_GOOD, -1, 0);
        steady = 1'b0;
    endtask

    // Hold the output off while one-byte frames keep coming; the input must stall
    task automatic test_backpressure();
        holds_requested++;
        for (int i = 0; i < 40; i++)
            send_frame(1, 4'd0, ups_pkg::PORT_W'($urandom), ups_pkg::QUEUE_W'($urandom),
                       HDR_GOOD, -1, 0);
    endtask

    // Mostly well-formed UDP frames with random content, plus noise and table churn
    task automatic test_random_traffic();
        int start;
        int pick;
        int len;
        int min_len;
        logic [ups_pkg::IHL_W-1:0]  ihl_n;
        logic [ups_pkg::PORT_W-1:0] dport;
        for (int k = 0; k < 8; k++)
            hot_ports[k] = ups_pkg::PORT_W'($urandom);
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            pick  = $urandom_range(99);
            ihl_n = ups_pkg::IHL_W'($urandom);
            dport = ($urandom_range(99) < 70) ? hot_ports[$urandom_range(7)]
                                              : ups_pkg::PORT_W'($urandom);
            if (pick < 8)
                write_random_entry();
            else if (pick < 28)
                send_frame($urandom_range(70, 1), ihl_n, dport, ups_pkg::QUEUE_W'($urandom),
                           hdr_flaw_t'($urandom_range(2)), -1, 2);
            else
            begin
                min_len = 4 * int'(ihl_n) + int'(ups_pkg::UDP_END_OFS) + 1;
                if (min_len < int'(ups_pkg::MIN_FRAME_BYTES))
                    min_len = int'(ups_pkg::MIN_FRAME_BYTES);
                len = min_len + $urandom_range(20);
                if ($urandom_range(99) < 5)
                    len = min_len - 1;
                send_frame(len, ihl_n, dport, ups_pkg::QUEUE_W'($urandom), HDR_GOOD,
                           ($urandom_range(99) < 10) ? int'($urandom_range(len - 1)) : -1,
                           2);
            end
        end
    endtask

    initial
    begin
        for (int k = 0; k < ups_pkg::TABLE_ENTRIES; k++)
        begin
            slot_valid[k] = 1'b0;
            slot_port[k]  = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_table_extremes();
        test_length_rules();
        test_header_rules();
        test_duplicate_ports();
        test_mid_frame_write();
        test_long_frame();
        test_backpressure();
        test_random_traffic();

        // Drain outstanding verdicts, then let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats: %0d frames and %0d table writes, one long gapless frame",
                 beats_sent, frames_sent, entry_writes);
        $display("Checked %0d redirect and %0d pass verdicts, %0d mismatches",
                 redirects_seen, passes_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/ups_pkg.sv
src/ups_front.sv
src/ups_fifo.sv
src/ups_back.sv
src/udp_port_packet_steering_top.sv
tb/tb_top.sv
